>>> sv/msd_pkg.sv
// Shared types, codes and segment tables for the seven-segment matrix driver.
// No dependencies; imported by msd_shape_gen and multiplexed_seven_segment_display.
package msd_pkg;

  // Fixed field widths
  localparam int unsigned CmdW      = 3;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned MsgW      = 3;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned LenW      = 2;
  localparam int unsigned NumW      = 11;
  localparam int unsigned NumWidthW = 2;
  localparam int unsigned CfgIdxW   = 2;

  // Digit layout: three digits, segments a..g in columns 0..6
  localparam int unsigned DigitCount = 3;
  localparam int unsigned SegW       = 7;

  // Special digit codes
  localparam logic [CodeW-1:0] CodeMinus = 4'd10;
  localparam logic [CodeW-1:0] CodeBlank = 4'd11;

  // Largest magnitude the display can show
  localparam logic [9:0] MagMax = 10'd999;

  typedef enum logic [CmdW-1:0] {
    CmdScan    = 3'd0,
    CmdSetLed  = 3'd1,
    CmdMessage = 3'd2,
    CmdDigits  = 3'd3,
    CmdNumber  = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegRowOnLevel    = 2'd0,
    RegColumnOnLevel = 2'd1
  } reg_idx_e;

  // Segment patterns for all digit positions, position 0 is leftmost
  typedef logic [DigitCount-1:0][SegW-1:0] digit_segs_t;

  // Digit-row update handed from the shape generator to the frame buffer
  typedef struct packed {
    logic        en;
    digit_segs_t seg;
  } digit_write_t;

  // Segment pattern of a digit code; unknown codes are blank
  function automatic logic [SegW-1:0] digit_shape(input logic [CodeW-1:0] code);
    logic [SegW-1:0] shape;
    unique case (code)
      4'd0:    shape = 7'h3F;
      4'd1:    shape = 7'h06;
      4'd2:    shape = 7'h5B;
      4'd3:    shape = 7'h4F;
      4'd4:    shape = 7'h66;
      4'd5:    shape = 7'h6D;
      4'd6:    shape = 7'h7D;
      4'd7:    shape = 7'h07;
      4'd8:    shape = 7'h7F;
      4'd9:    shape = 7'h6F;
      4'd10:   shape = 7'h40;
      default: shape = 7'h00;
    endcase
    return shape;
  endfunction

  // Fixed three-letter messages
  function automatic digit_segs_t message_shape(input logic [MsgW-1:0] idx);
    digit_segs_t segs;
    unique case (idx)
      3'd0:    segs = {7'h3F, 7'h76, 7'h39};  // CHO
      3'd1:    segs = {7'h37, 7'h3F, 7'h00};  // On
      3'd2:    segs = {7'h71, 7'h71, 7'h3F};  // OFF
      3'd3:    segs = {7'h37, 7'h3F, 7'h5E};  // dOn
      3'd4:    segs = {7'h50, 7'h50, 7'h79};  // Err
      3'd5:    segs = {7'h1C, 7'h79, 7'h6D};  // SEu
      3'd6:    segs = {7'h5E, 7'h79, 7'h6D};  // SEd
      default: segs = '0;                     // blank
    endcase
    return segs;
  endfunction

endpackage

>>> sv/msd_shape_gen.sv
// Segment pattern generation for the three digit rows (messages, codes, numbers).
// Depends on msd_pkg.
module msd_shape_gen (
  input  logic [msd_pkg::CmdW-1:0]      cmd_i,
  input  logic [msd_pkg::MsgW-1:0]      message_index_i,
  input  logic [msd_pkg::CodeW-1:0]     string_code_0_i,
  input  logic [msd_pkg::CodeW-1:0]     string_code_1_i,
  input  logic [msd_pkg::CodeW-1:0]     string_code_2_i,
  input  logic [msd_pkg::LenW-1:0]      string_length_i,
  input  logic signed [msd_pkg::NumW-1:0] number_value_i,
  input  logic [msd_pkg::NumWidthW-1:0] number_width_i,
  output msd_pkg::digit_write_t         write_o
);
  import msd_pkg::*;

  logic                 neg;
  logic [NumW-1:0]      mag_raw;
  logic [9:0]           mag;
  logic [15:0]          hund_prod;
  logic [3:0]           hund;
  logic [9:0]           rem_full;
  logic [6:0]           rem;
  logic [14:0]          tens_prod;
  logic [3:0]           tens;
  logic [6:0]           unit_full;
  logic [CodeW-1:0]     unit;
  logic [LenW-1:0]      len;
  logic [DigitCount-1:0][CodeW-1:0] codes;
  digit_segs_t          code_segs;
  digit_segs_t          num_segs;

  // Magnitude with clamp to 999
  assign neg     = number_value_i[NumW-1];
  assign mag_raw = neg ? (NumW'(0) - NumW'(number_value_i)) : NumW'(number_value_i);
  assign mag     = (mag_raw > NumW'(MagMax)) ? MagMax : mag_raw[9:0];

  // Decimal digits by reciprocal multiplication (exact for values below 1000)
  assign hund_prod = 16'(mag) * 16'd41;
  assign hund      = hund_prod[15:12];
  assign rem_full  = mag - 10'(hund) * 10'd100;
  assign rem       = rem_full[6:0];
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign unit_full = rem - 7'(tens) * 7'd10;
  assign unit      = unit_full[CodeW-1:0];

  // Number layout: units always, tens by width, left digit minus or hundreds
  always_comb begin
    num_segs[2] = digit_shape(unit);
    num_segs[1] = (number_width_i > 2'd1) ? digit_shape(tens) : digit_shape(CodeBlank);
    if (neg) begin
      num_segs[0] = digit_shape(CodeMinus);
    end else if (number_width_i > 2'd2) begin
      num_segs[0] = digit_shape(hund);
    end else begin
      num_segs[0] = digit_shape(CodeBlank);
    end
  end

  // Digit codes, positions past the length are blank
  assign codes = {string_code_2_i, string_code_1_i, string_code_0_i};
  assign len   = (32'(string_length_i) > DigitCount) ? LenW'(DigitCount) : string_length_i;

  always_comb begin
    for (int i = 0; i < DigitCount; i++) begin
      code_segs[i] = (32'(len) > i) ? digit_shape(codes[i]) : digit_shape(CodeBlank);
    end
  end

  // Select the source by command
  always_comb begin
    write_o = '0;
    unique case (cmd_e'(cmd_i))
      CmdMessage: begin
        write_o.en  = 1'b1;
        write_o.seg = message_shape(message_index_i);
      end
      CmdDigits: begin
        write_o.en  = 1'b1;
        write_o.seg = code_segs;
      end
      CmdNumber: begin
        write_o.en  = 1'b1;
        write_o.seg = num_segs;
      end
      default: begin
        write_o = '0;
      end
    endcase
  end

endmodule

>>> sv/multiplexed_seven_segment_display.sv
// Top level of the multiplexed seven-segment LED matrix driver.
// Depends on msd_pkg and msd_shape_gen.
//
// One request is taken per clock cycle (busy_o stays low) and its result
// appears on row_lines_o / column_lines_o with valid_o once the request
// has passed the input register and then the frame buffer update and pin
// register. Every request, including ones with an unused command code,
// produces exactly one result, which reports the pin levels after that
// request's update. The receiver cannot stall the block. A scan tick
// switches the previous row off, loads the columns of the current row and
// switches that row on. Configuration writes (pin polarities) are always
// ready and take effect on the next result.
module multiplexed_seven_segment_display #(
  parameter int unsigned ROW_COUNT    = 4,
  parameter int unsigned COLUMN_COUNT = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [msd_pkg::CmdW-1:0]        cmd_i,
  input  logic [msd_pkg::AddrW-1:0]       led_address_i,
  input  logic                            led_on_i,
  input  logic [msd_pkg::MsgW-1:0]        message_index_i,
  input  logic [msd_pkg::CodeW-1:0]       string_code_0_i,
  input  logic [msd_pkg::CodeW-1:0]       string_code_1_i,
  input  logic [msd_pkg::CodeW-1:0]       string_code_2_i,
  input  logic [msd_pkg::LenW-1:0]        string_length_i,
  input  logic signed [msd_pkg::NumW-1:0] number_value_i,
  input  logic [msd_pkg::NumWidthW-1:0]   number_width_i,
  // Result channel
  output logic                            valid_o,
  output logic [ROW_COUNT-1:0]            row_lines_o,
  output logic [COLUMN_COUNT-1:0]         column_lines_o,
  // Configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [msd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic                            cfg_data_i
);
  import msd_pkg::*;

  localparam int unsigned RowIdxW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  // Input register
  logic                  in_valid_q;
  logic [CmdW-1:0]       cmd_q;
  logic [AddrW-1:0]      led_address_q;
  logic                  led_on_q;
  logic [MsgW-1:0]       message_index_q;
  logic [CodeW-1:0]      string_code_0_q;
  logic [CodeW-1:0]      string_code_1_q;
  logic [CodeW-1:0]      string_code_2_q;
  logic [LenW-1:0]       string_length_q;
  logic signed [NumW-1:0] number_value_q;
  logic [NumWidthW-1:0]  number_width_q;

  // Block state
  logic [ROW_COUNT-1:0][COLUMN_COUNT-1:0] fb_q, fb_d;
  logic [RowIdxW-1:0]       scan_row_q, scan_row_d, prev_row;
  logic [ROW_COUNT-1:0]     row_pins_q, row_pins_d;
  logic [COLUMN_COUNT-1:0]  col_pins_q, col_pins_d;
  logic                     row_on_level_q;
  logic                     col_on_level_q;

  // Result register
  logic                     valid_q;
  logic [ROW_COUNT-1:0]     row_lines_q;
  logic [COLUMN_COUNT-1:0]  column_lines_q;

  digit_write_t             dwrite;
  logic                     accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q           <= cmd_i;
      led_address_q   <= led_address_i;
      led_on_q        <= led_on_i;
      message_index_q <= message_index_i;
      string_code_0_q <= string_code_0_i;
      string_code_1_q <= string_code_1_i;
      string_code_2_q <= string_code_2_i;
      string_length_q <= string_length_i;
      number_value_q  <= number_value_i;
      number_width_q  <= number_width_i;
    end
  end

  // Digit row patterns
  msd_shape_gen u_shape_gen (
    .cmd_i           (cmd_q),
    .message_index_i (message_index_q),
    .string_code_0_i (string_code_0_q),
    .string_code_1_i (string_code_1_q),
    .string_code_2_i (string_code_2_q),
    .string_length_i (string_length_q),
    .number_value_i  (number_value_q),
    .number_width_i  (number_width_q),
    .write_o         (dwrite)
  );

  assign prev_row = (scan_row_q == '0) ? RowIdxW'(ROW_COUNT - 1) : scan_row_q - 1'b1;

  // Frame buffer and pin update for the registered request
  always_comb begin
    fb_d       = fb_q;
    scan_row_d = scan_row_q;
    row_pins_d = row_pins_q;
    col_pins_d = col_pins_q;
    if (in_valid_q) begin
      unique case (cmd_e'(cmd_q))
        CmdScan: begin
          row_pins_d[prev_row]   = 1'b0;
          col_pins_d             = fb_q[scan_row_q];
          row_pins_d[scan_row_q] = 1'b1;
          scan_row_d = (32'(scan_row_q) == ROW_COUNT - 1) ? '0 : scan_row_q + 1'b1;
        end
        CmdSetLed: begin
          for (int r = 0; r < ROW_COUNT; r++) begin
            for (int c = 0; c < COLUMN_COUNT; c++) begin
              if (32'(led_address_q) == r * COLUMN_COUNT + c) begin
                fb_d[r][c] = led_on_q;
              end
            end
          end
        end
        CmdMessage, CmdDigits, CmdNumber: begin
          for (int i = 0; i < DigitCount; i++) begin
            if (i + 1 < ROW_COUNT) begin
              fb_d[i+1][SegW-1:0] = dwrite.seg[i];
            end
          end
        end
        default: begin
          fb_d = fb_q;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q       <= '0;
      scan_row_q <= '0;
      row_pins_q <= '0;
      col_pins_q <= '0;
    end else begin
      fb_q       <= fb_d;
      scan_row_q <= scan_row_d;
      row_pins_q <= row_pins_d;
      col_pins_q <= col_pins_d;
    end
  end

  // Polarity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_on_level_q <= 1'b1;
      col_on_level_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegRowOnLevel:    row_on_level_q <= cfg_data_i;
        RegColumnOnLevel: col_on_level_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Result register: pin levels after the update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      row_lines_q    <= row_pins_d ^ {ROW_COUNT{~row_on_level_q}};
      column_lines_q <= col_pins_d ^ {COLUMN_COUNT{~col_on_level_q}};
    end
  end

  assign valid_o        = valid_q;
  assign row_lines_o    = row_lines_q;
  assign column_lines_o = column_lines_q;

  // Every request gives a result once it has passed the input and result registers
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 valid_o)
    else $error("request did not produce a result");

  // No result without a matching earlier request
  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 2))
    else $error("result without a request");

  // At most one row is ever driven
  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(row_pins_q))
    else $error("more than one row active");

  // Scan pointer stays inside the matrix
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(scan_row_q) < ROW_COUNT)
    else $error("scan row out of range");

  // Only a scan tick moves the scan pointer
  a_scan_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_row_q != $past(scan_row_q)) |-> ($past(in_valid_q) && $past(cmd_q) == CmdScan))
    else $error("scan row changed without a scan tick");

endmodule

>>> tb/multiplexed_seven_segment_display_test.sv
// Self-checking testbench for the multiplexed seven-segment LED matrix driver.
// Depends on msd_pkg and the multiplexed_seven_segment_display RTL; it predicts
// each pin report in a model of its own and compares every result strobe.
`timescale 1ns / 1ps

module multiplexed_seven_segment_display_test;
  import msd_pkg::*;

  localparam int unsigned RowCount    = 4;
  localparam int unsigned ColumnCount = 8;
  localparam int unsigned CycleLimit  = 200_000;

  // Command codes past the last defined one
  localparam logic [CmdW-1:0] CmdFirstUnused = 3'd5;
  localparam logic [CmdW-1:0] CmdLastUnused  = 3'd7;

  // Digit codes with no shape of their own
  localparam logic [CodeW-1:0] CodeFirstBad = 4'd12;
  localparam logic [CodeW-1:0] CodeLastBad  = 4'd15;

  // Message indexes used by name
  localparam logic [MsgW-1:0] MsgCho = 3'd0;
  localparam logic [MsgW-1:0] MsgErr = 3'd4;

  // Segment patterns a..g of digit codes 0..11 (index 0 on the right)
  localparam logic [11:0][SegW-1:0] DigitSegs = {
    7'h00, 7'h40, 7'h6F, 7'h7F, 7'h07, 7'h7D,
    7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  // Fixed messages, each {right, middle, left}: blank SEd SEu Err dOn OFF On CHO
  localparam logic [7:0][DigitCount-1:0][SegW-1:0] MessageSegs = {
    {7'h00, 7'h00, 7'h00},
    {7'h5E, 7'h79, 7'h6D},
    {7'h1C, 7'h79, 7'h6D},
    {7'h50, 7'h50, 7'h79},
    {7'h37, 7'h3F, 7'h5E},
    {7'h71, 7'h71, 7'h3F},
    {7'h37, 7'h3F, 7'h00},
    {7'h3F, 7'h76, 7'h39}
  };

  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic [AddrW-1:0]       addr;
    logic                   led_on;
    logic [MsgW-1:0]        msg;
    logic [CodeW-1:0]       code0;
    logic [CodeW-1:0]       code1;
    logic [CodeW-1:0]       code2;
    logic [LenW-1:0]        len;
    logic [NumW-1:0]        value;
    logic [NumWidthW-1:0]   width;
  } request_t;

  typedef struct packed {
    logic [RowCount-1:0]    rows;
    logic [ColumnCount-1:0] columns;
  } pins_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [CmdW-1:0]             cmd_i = '0;
  logic [AddrW-1:0]            led_address_i = '0;
  logic                        led_on_i = 1'b0;
  logic [MsgW-1:0]             message_index_i = '0;
  logic [CodeW-1:0]            string_code_0_i = '0;
  logic [CodeW-1:0]            string_code_1_i = '0;
  logic [CodeW-1:0]            string_code_2_i = '0;
  logic [LenW-1:0]             string_length_i = '0;
  logic signed [NumW-1:0]      number_value_i = '0;
  logic [NumWidthW-1:0]        number_width_i = '0;
  logic                        valid_o;
  logic [RowCount-1:0]         row_lines_o;
  logic [ColumnCount-1:0]      column_lines_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxW-1:0]          cfg_index_i = '0;
  logic                        cfg_data_i = 1'b0;

  // Display model: frame buffer, scan position, active pins, polarities
  logic [ColumnCount-1:0] frame [RowCount];
  int unsigned            scan_row;
  logic [RowCount-1:0]    row_active;
  logic [ColumnCount-1:0] column_active;
  logic                   row_on_level;
  logic                   column_on_level;

  pins_t expected_pins [$];
  int    requests_sent;
  int    results_seen;
  int    error_count;
  int    idle_pct;

  multiplexed_seven_segment_display #(
    .ROW_COUNT    (RowCount),
    .COLUMN_COUNT (ColumnCount)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .led_address_i   (led_address_i),
    .led_on_i        (led_on_i),
    .message_index_i (message_index_i),
    .string_code_0_i (string_code_0_i),
    .string_code_1_i (string_code_1_i),
    .string_code_2_i (string_code_2_i),
    .string_length_i (string_length_i),
    .number_value_i  (number_value_i),
    .number_width_i  (number_width_i),
    .valid_o         (valid_o),
    .row_lines_o     (row_lines_o),
    .column_lines_o  (column_lines_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shape of one digit code; codes past blank show nothing
  function automatic logic [SegW-1:0] segments_of_code(input int unsigned code);
    return (code < CodeFirstBad) ? DigitSegs[code] : '0;
  endfunction

  // Apply one request to the display model and return the pin levels after it
  function automatic pins_t display_after_request(input request_t r);
    pins_t                           p;
    digit_segs_t                     segs;
    logic [DigitCount-1:0][CodeW-1:0] codes;
    int unsigned                     prev;
    int unsigned                     len;
    int unsigned                     mag;
    logic                            negative;
    logic                            write_digits;
    write_digits = 1'b0;
    segs = '0;
    case (r.cmd)
      CmdScan: begin
        prev = (scan_row == 0) ? RowCount - 1 : scan_row - 1;
        row_active[prev] = 1'b0;
        column_active = frame[scan_row];
        row_active[scan_row] = 1'b1;
        scan_row = (scan_row + 1) % RowCount;
      end
      CmdSetLed: begin
        if (r.addr < RowCount * ColumnCount)
          frame[r.addr / ColumnCount][r.addr % ColumnCount] = r.led_on;
      end
      CmdMessage: begin
        segs = MessageSegs[r.msg];
        write_digits = 1'b1;
      end
      CmdDigits: begin
        codes = {r.code2, r.code1, r.code0};
        len = (r.len > DigitCount) ? DigitCount : r.len;
        for (int i = 0; i < DigitCount; i++)
          segs[i] = segments_of_code(i < len ? codes[i] : CodeBlank);
        write_digits = 1'b1;
      end
      CmdNumber: begin
        negative = r.value[NumW-1];
        mag = negative ? (1 << NumW) - r.value : r.value;
        if (mag > MagMax) mag = MagMax;
        segs[2] = segments_of_code(mag % 10);
        segs[1] = segments_of_code(r.width > 1 ? (mag / 10) % 10 : CodeBlank);
        segs[0] = segments_of_code(negative ? CodeMinus :
                                   (r.width > 2 ? mag / 100 : CodeBlank));
        write_digits = 1'b1;
      end
      default: ;
    endcase
    // Digits sit in rows 1..3, segment columns only; column 7 is kept
    if (write_digits)
      for (int i = 0; i < DigitCount; i++)
        if (i + 1 < RowCount) frame[i + 1][SegW-1:0] = segs[i];
    p.rows    = row_on_level ? row_active : ~row_active;
    p.columns = column_on_level ? column_active : ~column_active;
    return p;
  endfunction

  // Request monitor and result checker
  always @(posedge clk_i) begin
    request_t seen;
    pins_t    want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegRowOnLevel:    row_on_level = cfg_data_i;
          RegColumnOnLevel: column_on_level = cfg_data_i;
          default: ;
        endcase
      end
      if (valid_o) begin
        results_seen++;
        if (expected_pins.size() == 0) begin
          $display("%0t: result with no request pending: rows %h columns %h",
                   $time, row_lines_o, column_lines_o);
          error_count++;
        end else begin
          want = expected_pins.pop_front();
          if (row_lines_o !== want.rows) begin
            $display("%0t: row_lines expected %h actual %h", $time, want.rows, row_lines_o);
            error_count++;
          end
          if (column_lines_o !== want.columns) begin
            $display("%0t: column_lines expected %h actual %h",
                     $time, want.columns, column_lines_o);
            error_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        seen.cmd    = cmd_i;
        seen.addr   = led_address_i;
        seen.led_on = led_on_i;
        seen.msg    = message_index_i;
        seen.code0  = string_code_0_i;
        seen.code1  = string_code_1_i;
        seen.code2  = string_code_2_i;
        seen.len    = string_length_i;
        seen.value  = number_value_i;
        seen.width  = number_width_i;
        expected_pins.push_back(display_after_request(seen));
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("multiplexed_seven_segment_display_test: FAIL");
    $finish;
  end

  // Every field but the value random over its full width, command as given
  function automatic request_t random_request(input logic [CmdW-1:0] cmd);
    request_t r;
    r.cmd    = cmd;
    r.addr   = AddrW'($urandom_range((1 << AddrW) - 1));
    r.led_on = 1'($urandom_range(1));
    r.msg    = MsgW'($urandom_range((1 << MsgW) - 1));
    r.code0  = CodeW'($urandom_range((1 << CodeW) - 1));
    r.code1  = CodeW'($urandom_range((1 << CodeW) - 1));
    r.code2  = CodeW'($urandom_range((1 << CodeW) - 1));
    r.len    = LenW'($urandom_range((1 << LenW) - 1));
    r.width  = NumWidthW'($urandom_range((1 << NumWidthW) - 1));
    // Mostly displayable values, some raw patterns past the clamp
    if ($urandom_range(99) < 85) r.value = NumW'($urandom_range(2 * MagMax) - MagMax);
    else r.value = NumW'($urandom_range((1 << NumW) - 1));
    return r;
  endfunction

  // Send one request, with a random gap before it at the current idle rate
  task automatic send_request(input request_t r);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i         <= 1'b1;
    cmd_i           <= r.cmd;
    led_address_i   <= r.addr;
    led_on_i        <= r.led_on;
    message_index_i <= r.msg;
    string_code_0_i <= r.code0;
    string_code_1_i <= r.code1;
    string_code_2_i <= r.code2;
    string_length_i <= r.len;
    number_value_i  <= r.value;
    number_width_i  <= r.width;
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
  endtask

  task automatic send_scans(input int unsigned count);
    repeat (count) send_request(random_request(CmdScan));
  endtask

  task automatic send_led(input int unsigned addr, input logic on);
    request_t r;
    r = random_request(CmdSetLed);
    r.addr = AddrW'(addr);
    r.led_on = on;
    send_request(r);
  endtask

  task automatic send_digits(input logic [CodeW-1:0] c0, input logic [CodeW-1:0] c1,
                             input logic [CodeW-1:0] c2, input int unsigned len);
    request_t r;
    r = random_request(CmdDigits);
    {r.code0, r.code1, r.code2} = {c0, c1, c2};
    r.len = LenW'(len);
    send_request(r);
  endtask

  task automatic send_number(input int value, input int unsigned width);
    request_t r;
    r = random_request(CmdNumber);
    r.value = NumW'(value);
    r.width = NumWidthW'(width);
    send_request(r);
  endtask

  // Wait until every result is in
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (results_seen < requests_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both polarity registers, back to back on one held request
  task automatic write_pin_levels(input logic row_level, input logic column_level);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegRowOnLevel;
    cfg_data_i  <= row_level;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= RegColumnOnLevel;
    cfg_data_i  <= column_level;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Off levels out of reset, then the row scan wrapping around
  task automatic test_scan_after_reset();
    send_scans(4);
  endtask

  // Corner addresses, set and clear
  task automatic test_set_led();
    send_led(0, 1'b1);
    send_led(RowCount * ColumnCount - 1, 1'b1);
    send_led(2 * ColumnCount - 1, 1'b1);
    send_led(0, 1'b0);
  endtask

  // Message, digit codes (minus, bad, short length), number layouts, scans
  task automatic test_display_commands();
    request_t r;
    r = random_request(CmdMessage);
    r.msg = MsgCho;
    send_request(r);
    send_digits(CodeMinus, CodeFirstBad, CodeLastBad, DigitCount);
    send_digits(4'd9, 4'd5, 4'd7, 1);
    send_number(-MagMax, 3);
    send_number(MagMax, 3);
    send_number(7, 0);
    send_number((1 << (NumW - 1)) - 1, 3);
    send_number(-(1 << (NumW - 1)), 1);
    send_number(42, 2);
    send_scans(4);
  endtask

  task automatic test_unused_commands();
    send_request(random_request(CmdFirstUnused));
    send_request(random_request(CmdLastUnused));
  endtask

  // Random bursts: a request (rarely an unused command), then up to five scans
  task automatic test_random_phase(input logic row_level, input logic column_level,
                                   input int idle, input int count);
    int               sent;
    int unsigned      scans;
    logic [CmdW-1:0]  cmd;
    drain_results();
    write_pin_levels(row_level, column_level);
    idle_pct = idle;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 6) cmd = CmdW'($urandom_range(CmdLastUnused, CmdFirstUnused));
      else cmd = CmdW'($urandom_range(CmdNumber, CmdSetLed));
      send_request(random_request(cmd));
      scans = $urandom_range(5);
      send_scans(scans);
      sent += 1 + scans;
    end
  endtask

  initial begin
    for (int i = 0; i < RowCount; i++) frame[i] = '0;
    scan_row        = 0;
    row_active      = '0;
    column_active   = '0;
    row_on_level    = 1'b1;
    column_on_level = 1'b1;
    requests_sent   = 0;
    results_seen    = 0;
    error_count     = 0;
    idle_pct        = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_scan_after_reset();
    test_set_led();
    test_display_commands();
    test_unused_commands();
    test_random_phase(1'b1, 1'b1, 0, 310);
    test_random_phase(1'b0, 1'b0, 82, 310);
    test_random_phase(1'b0, 1'b1, 16, 310);
    test_random_phase(1'b1, 1'b0, 0, 310);
    test_random_phase(1'b1, 1'b1, 82, 310);
    test_random_phase(1'b0, 1'b0, 16, 300);
    drain_results();

    if (expected_pins.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_pins.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("multiplexed_seven_segment_display_test: PASS");
    end else begin
      $display("multiplexed_seven_segment_display_test: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/msd_pkg.sv
sv/msd_shape_gen.sv
sv/multiplexed_seven_segment_display.sv
tb/multiplexed_seven_segment_display_test.sv
